>>> rtl/sha1mh_pkg.sv
package sha1mh_pkg;

   localparam int WordWidth  = 32;
   localparam int IndexWidth = 3;

   // initial chaining words, index 0 is the first word
   localparam logic [4:0][WordWidth-1:0] Iv = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [WordWidth-1:0] K0 = 32'h5a827999;
   localparam logic [WordWidth-1:0] K1 = 32'h6ed9eba1;
   localparam logic [WordWidth-1:0] K2 = 32'h8f1bbcdc;
   localparam logic [WordWidth-1:0] K3 = 32'hca62c1d6;

   localparam logic [7:0]            PadMarker   = 8'h80;
   localparam logic [3:0]            LengthWord  = 4'd14;
   localparam logic [IndexWidth-1:0] LastIndex   = 3'd4;

   // one message schedule word on its way to the compression engine
   typedef struct packed {
      logic                 final_word;
      logic [WordWidth-1:0] word;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

>>> rtl/sha1_message_hasher.sv
// channel  dir  tdata            tuser          tlast
// req_     in   [7:0] data_byte  [0] has_byte   last
// rsp_     out  [31:0] digest    [2:0] index    digest_last
//
// req_ takes byte transactions outside padding while the queue has room; the engine spends
// 80 rounds plus the feed-forward add on a block but takes its words only in the first 16
// rounds, so collection runs ahead by at most QueueDepth words, with a default depth of 4
// padding words enter the queue at one per cycle while it has room; a digest goes out on
// rsp_ as words with index 0 to 4
// synchronous reset restores the initial chaining words; no clearing pass
// a stalled rsp_ side halts the engine only in the digest phase; a full queue stalls req_

module sha1_message_hasher #(
   parameter int QueueDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   logic                        push;
   logic                        pop;
   sha1mh_pkg::entry_type       push_entry;
   sha1mh_pkg::entry_type       head;
   sha1mh_pkg::fifo_status_type fifo_status;

   sha1mh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .push        (push),
      .push_entry  (push_entry),
      .fifo_status (fifo_status)
   );

   sha1mh_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   sha1mh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

>>> rtl/sha1mh_front.sv
module sha1mh_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] data_byte
   input  logic                        req_tuser,   // [0] has_byte
   input  logic                        req_tlast,
   output logic                        push,
   output sha1mh_pkg::entry_type       push_entry,
   input  sha1mh_pkg::fifo_status_type fifo_status
);

   localparam logic [1:0] StCollect = 2'd0;
   localparam logic [1:0] StMark    = 2'd1;
   localparam logic [1:0] StZero    = 2'd2;
   localparam logic [1:0] StLenLo   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  pending_ff, pending_in;
   logic [31:0] word_ff, word_in;
   logic [63:0] bits_ff, bits_in;
   logic        accept;
   logic [31:0] packed_word;
   logic [31:0] mark_word;

   assign req_tready  = (state_ff == StCollect) && !fifo_status.full;
   assign accept      = req_tvalid && req_tready;
   assign packed_word = {word_ff[23:0], req_tdata};

   // partial word closed with the pad marker
   always_comb begin
      case (pending_ff[1:0])
         2'd0:    mark_word = {sha1mh_pkg::PadMarker, 24'h0};
         2'd1:    mark_word = {word_ff[7:0], sha1mh_pkg::PadMarker, 16'h0};
         2'd2:    mark_word = {word_ff[15:0], sha1mh_pkg::PadMarker, 8'h0};
         2'd3:    mark_word = {word_ff[23:0], sha1mh_pkg::PadMarker};
         default: mark_word = '0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      word_in    = word_ff;
      bits_in    = bits_ff;
      push       = 1'b0;
      push_entry = '0;
      case (state_ff)
         StCollect: begin
            if (accept) begin
               if (req_tuser) begin
                  word_in    = packed_word;
                  pending_in = pending_ff + 6'd1;
                  bits_in    = bits_ff + 64'd8;
                  if (pending_ff[1:0] == 2'd3) begin
                     push            = 1'b1;
                     push_entry.word = packed_word;
                  end
               end
               if (req_tlast) begin
                  state_in = StMark;
               end
            end
         end
         StMark: begin
            if (!fifo_status.full) begin
               push            = 1'b1;
               push_entry.word = mark_word;
               pending_in      = {pending_ff[5:2] + 4'd1, 2'b00};
               state_in        = StZero;
            end
         end
         StZero: begin
            if (!fifo_status.full) begin
               push       = 1'b1;
               pending_in = pending_ff + 6'd4;
               if (pending_ff[5:2] == sha1mh_pkg::LengthWord) begin
                  push_entry.word = bits_ff[63:32];
                  state_in        = StLenLo;
               end
            end
         end
         StLenLo: begin
            if (!fifo_status.full) begin
               push                  = 1'b1;
               push_entry.word       = bits_ff[31:0];
               push_entry.final_word = 1'b1;
               pending_in            = '0;
               bits_in               = '0;
               state_in              = StCollect;
            end
         end
         default: begin
            state_in = StCollect;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StCollect;
         pending_ff <= '0;
         bits_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         bits_ff    <= bits_in;
      end
      word_ff <= word_in;
   end

endmodule

>>> rtl/sha1mh_fifo.sv
module sha1mh_fifo #(
   parameter int Depth = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sha1mh_pkg::entry_type       push_entry,
   input  logic                        pop,
   output sha1mh_pkg::entry_type       head,
   output sha1mh_pkg::fifo_status_type status
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast  = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(Depth);

   sha1mh_pkg::entry_type mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CountMax);
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      (pop |-> !status.empty) && (count_ff <= CountMax))
      else $error("queue underflow or count out of range");

endmodule

>>> rtl/sha1mh_core.sv
module sha1mh_core (
   input  logic                        clock,
   input  logic                        reset,
   input  sha1mh_pkg::entry_type       head,
   input  sha1mh_pkg::fifo_status_type fifo_status,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [31:0] digest_word
   output logic [2:0]                  rsp_tuser,   // [2:0] word_index
   output logic                        rsp_tlast
);

   localparam logic [1:0] StRound = 2'd0;
   localparam logic [1:0] StAdd   = 2'd1;
   localparam logic [1:0] StEmit  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [6:0]        round_ff, round_in;
   logic [4:0][31:0]  v_ff, v_in;
   logic [4:0][31:0]  h_ff, h_in;
   logic [15:0][31:0] w_ff, w_in;
   logic              fin_ff, fin_in;
   logic [2:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;

   logic        early;
   logic        step;
   logic        load;
   logic [31:0] sched;
   logic [31:0] wt;
   logic [31:0] f;
   logic [31:0] k;
   logic [31:0] tmp;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_index_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign early = (round_ff < 7'd16);
   assign sched = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign wt    = early ? head.word : {sched[30:0], sched[31]};
   assign pop   = (state_ff == StRound) && early && !fifo_status.empty;
   assign step  = (state_ff == StRound) && (!early || !fifo_status.empty);
   assign load  = (state_ff == StEmit) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (round_ff < 7'd20) begin
         f = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
         k = sha1mh_pkg::K0;
      end else if (round_ff < 7'd40) begin
         f = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k = sha1mh_pkg::K1;
      end else if (round_ff < 7'd60) begin
         f = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
         k = sha1mh_pkg::K2;
      end else begin
         f = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k = sha1mh_pkg::K3;
      end
   end

   assign tmp = {v_ff[0][26:0], v_ff[0][31:27]} + f + v_ff[4] + k + wt;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      v_in         = v_ff;
      h_in         = h_ff;
      w_in         = w_ff;
      fin_in       = fin_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         StRound: begin
            if (step) begin
               v_in[0] = tmp;
               v_in[1] = v_ff[0];
               v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
               v_in[3] = v_ff[2];
               v_in[4] = v_ff[3];
               w_in    = {wt, w_ff[15:1]};
               if (round_ff == 7'd15) begin
                  fin_in = head.final_word;
               end
               if (round_ff == 7'd79) begin
                  round_in = '0;
                  state_in = StAdd;
               end else begin
                  round_in = round_ff + 7'd1;
               end
            end
         end
         StAdd: begin
            for (int i = 0; i < 5; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
               v_in[i] = h_ff[i] + v_ff[i];
            end
            if (fin_ff) begin
               idx_in   = '0;
               state_in = StEmit;
            end else begin
               state_in = StRound;
            end
         end
         StEmit: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = h_ff[idx_ff];
               rsp_index_in = idx_ff;
               rsp_last_in  = (idx_ff == sha1mh_pkg::LastIndex);
               idx_in       = idx_ff + 3'd1;
               if (idx_ff == sha1mh_pkg::LastIndex) begin
                  h_in     = sha1mh_pkg::Iv;
                  v_in     = sha1mh_pkg::Iv;
                  fin_in   = 1'b0;
                  state_in = StRound;
               end
            end
         end
         default: begin
            state_in = StRound;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StRound;
         round_ff     <= '0;
         v_ff         <= sha1mh_pkg::Iv;
         h_ff         <= sha1mh_pkg::Iv;
         fin_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         v_ff         <= v_in;
         h_ff         <= h_in;
         fin_ff       <= fin_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff         <= w_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StAdd) |-> ($past(state_ff) == StRound && $past(round_ff) == 7'd79))
      else $error("feed-forward without 80 rounds");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == sha1mh_pkg::LastIndex))
      else $error("last digest word at wrong index");
   assert property (@(posedge clock) disable iff (reset)
      (load && idx_ff == sha1mh_pkg::LastIndex)
         |=> (state_ff == StRound && round_ff == 7'd0 && h_ff[0] == sha1mh_pkg::Iv[0]))
      else $error("chaining words not reinitialised after digest");

endmodule
